// ----- src/ptc_pkg.sv -----
// Package for the pressure/temperature compensation block.
// Holds payload structs, register indexes and 32-bit wrap helpers.
// No dependencies.
`default_nettype none
package ptc_pkg;

  localparam int DivSteps = 32;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] RegTempCal  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegPressLow = 8'd1;
  localparam logic [CfgIdxW-1:0] RegPressMid = 8'd2;
  localparam logic [CfgIdxW-1:0] RegPressHi  = 8'd3;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        pressure_pa;
  } out_item_t;

  // side data that rides along with the divider
  typedef struct packed {
    logic [31:0] temp;
    logic        halve;
    logic        zero;
  } div_tag_t;

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    asr = $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] w);
    sx16 = {{16{w[15]}}, w};
  endfunction

endpackage
`default_nettype wire

// ----- src/pressure_temp_compensation_unit.sv -----
// Pressure/temperature compensation, 32-bit integer scheme.
// The pipeline has 11 front stages, 32 divider stages and 3 back
// stages. Throughput: one item per cycle while the output is taken.
// The whole pipeline holds while the output register waits to be taken.
// Synchronous active-low reset clears valid bits and calibration registers.
`default_nettype none
module pressure_temp_compensation_unit import ptc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [47:0] tcal_r;
  logic [63:0] plo_r, pmid_r;
  logic [15:0] phi_r;
  logic        en, f_vld, d_vld;
  logic [31:0] num, dvs, quo;
  div_tag_t    f_tag, d_tag;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0;
      plo_r  <= '0;
      pmid_r <= '0;
      phi_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegTempCal:  tcal_r <= cfg_data[47:0];
        RegPressLow: plo_r  <= cfg_data;
        RegPressMid: pmid_r <= cfg_data;
        RegPressHi:  phi_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk, .rst_n, .en,
    .in_vld(in_valid), .in_item(in_data),
    .tcal(tcal_r), .pcal_lo(plo_r), .pcal_mid(pmid_r),
    .out_vld(f_vld), .num, .dvs, .tag(f_tag)
  );

  ptc_div u_div (
    .clk, .rst_n, .en,
    .in_vld(f_vld), .num, .dvs, .in_tag(f_tag),
    .out_vld(d_vld), .quo, .out_tag(d_tag)
  );

  ptc_back u_back (
    .clk, .rst_n, .en,
    .in_vld(d_vld), .quo, .tag(d_tag),
    .pcal_mid(pmid_r), .pcal_hi(phi_r),
    .out_vld(out_valid), .out_item(out_data)
  );

endmodule
`default_nettype wire

// ----- src/ptc_front.sv -----
// Front pipeline: fine temperature, temperature output and the pressure
// terms up to the divider operands. Depends on ptc_pkg.
`default_nettype none
module ptc_front import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire in_item_t    in_item,
  input  wire logic [47:0] tcal,
  input  wire logic [63:0] pcal_lo,
  input  wire logic [63:0] pcal_mid,
  output logic             out_vld,
  output logic [31:0]      num,
  output logic [31:0]      dvs,
  output div_tag_t         tag
);

  logic [11:1] v_r;
  logic [31:0] ap_r [1:8];
  logic [31:0] temp_r [6:11];
  logic [31:0] x1_r, d_r, m1_r, dd_r, at_r, m2_r, fine_r, tmul_r, pa_r, q_r;
  logic [31:0] qq_r, ap5_r, p2a_r, p2b_r, b1_r, p3q_r, b2_r, b_r, a2_r, mm_r, pp_r;
  logic [31:0] dv_r, pm_r, dv11_r, num_r;
  logic        halve_r, zero_r;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6;
  assign t1 = {16'd0, tcal[15:0]};
  assign t2 = sx16(tcal[31:16]);
  assign t3 = sx16(tcal[47:32]);
  assign p1 = {16'd0, pcal_lo[15:0]};
  assign p2 = sx16(pcal_lo[31:16]);
  assign p3 = sx16(pcal_lo[47:32]);
  assign p4 = sx16(pcal_lo[63:48]);
  assign p5 = sx16(pcal_mid[15:0]);
  assign p6 = sx16(pcal_mid[31:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[10:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= {15'd0, in_item.raw_temp[19:3]} - {15'd0, t1[15:0], 1'b0};
      d_r    <= {16'd0, in_item.raw_temp[19:4]} - t1;
      ap_r[1] <= {12'd0, in_item.raw_pressure};
      for (int i = 2; i <= 8; i++) ap_r[i] <= ap_r[i-1];
      m1_r   <= x1_r * t2;
      dd_r   <= d_r * d_r;
      at_r   <= asr(m1_r, 5'd11);
      m2_r   <= asr(dd_r, 5'd12) * t3;
      fine_r <= at_r + asr(m2_r, 5'd14);
      tmul_r <= fine_r * 32'd5 + 32'd128;
      pa_r   <= asr(fine_r, 5'd1) - 32'd64000;
      q_r    <= asr(asr(fine_r, 5'd1) - 32'd64000, 5'd2);
      temp_r[6] <= asr(tmul_r, 5'd8);
      for (int i = 7; i <= 11; i++) temp_r[i] <= temp_r[i-1];
      qq_r   <= q_r * q_r;
      ap5_r  <= pa_r * p5;
      p2a_r  <= p2 * pa_r;
      b1_r   <= asr(qq_r, 5'd11) * p6;
      p3q_r  <= p3 * asr(qq_r, 5'd13);
      p2b_r  <= p2a_r;
      b2_r   <= {ap5_r[30:0], 1'b0};
      b_r    <= asr(b1_r + b2_r, 5'd2) + {p4[15:0], 16'd0};
      a2_r   <= asr(asr(p3q_r, 5'd3) + asr(p2b_r, 5'd1), 5'd18);
      mm_r   <= (32'd32768 + a2_r) * p1;
      pp_r   <= (32'd1048576 - ap_r[8]) - asr(b_r, 5'd12);
      dv_r   <= asr(mm_r, 5'd15);
      pm_r   <= pp_r * 32'd3125;
      // below 2^31 double first, else divide then double
      halve_r <= pm_r[31];
      num_r   <= pm_r[31] ? pm_r : {pm_r[30:0], 1'b0};
      zero_r  <= (dv_r == 32'd0);
      dv11_r  <= dv_r;
    end
  end

  assign out_vld    = v_r[11];
  assign num        = num_r;
  assign dvs        = dv11_r;
  assign tag.temp   = temp_r[11];
  assign tag.halve  = halve_r;
  assign tag.zero   = zero_r;

endmodule
`default_nettype wire

// ----- src/ptc_div.sv -----
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Carries a side tag with each item. Depends on ptc_pkg.
`default_nettype none
module ptc_div import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [31:0] num,
  input  wire logic [31:0] dvs,
  input  wire div_tag_t    in_tag,
  output logic             out_vld,
  output logic [31:0]      quo,
  output div_tag_t         out_tag
);

  logic [DivSteps:0] v_r;
  logic [32:0]       rem_r [0:DivSteps];
  logic [31:0]       nq_r  [0:DivSteps];
  logic [31:0]       dv_r  [0:DivSteps];
  div_tag_t          tag_r [0:DivSteps];

  assign v_r[0]     = in_vld;
  assign rem_r[0]   = '0;
  assign nq_r[0]    = num;
  assign dv_r[0]    = dvs;
  assign tag_r[0]   = in_tag;

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    logic [32:0] sh;
    logic        ge;
    assign sh = {rem_r[k-1][31:0], nq_r[k-1][31]};
    assign ge = (sh >= {1'b0, dv_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? sh - {1'b0, dv_r[k-1]} : sh;
        nq_r[k]  <= {nq_r[k-1][30:0], ge};
        dv_r[k]  <= dv_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_vld = v_r[DivSteps];
  assign quo     = nq_r[DivSteps];
  assign out_tag = tag_r[DivSteps];

endmodule
`default_nettype wire

// ----- src/ptc_back.sv -----
// Back pipeline: quotient fix-up and second-order pressure correction,
// ending in the output register. Depends on ptc_pkg.
`default_nettype none
module ptc_back import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_vld,
  input  wire logic [31:0] quo,
  input  wire div_tag_t    tag,
  input  wire logic [63:0] pcal_mid,
  input  wire logic [15:0] pcal_hi,
  output logic             out_vld,
  output out_item_t        out_item
);

  logic [3:1]  v_r;
  logic [31:0] p1_r, p2_r, sq_r, m8_r, m8b_r, mp9_r, t1_r, t2_r;
  logic        z1_r, z2_r;
  out_item_t   out_r;
  logic [31:0] p, p7, p8, p9, corr;

  assign p7 = sx16(pcal_mid[47:32]);
  assign p8 = sx16(pcal_mid[63:48]);
  assign p9 = sx16(pcal_hi);
  assign p  = tag.halve ? {quo[30:0], 1'b0} : quo;
  assign corr = asr(asr(mp9_r, 5'd12) + asr(m8b_r, 5'd13) + p7, 5'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p;
      sq_r  <= {3'd0, p[31:3]} * {3'd0, p[31:3]};
      m8_r  <= {2'd0, p[31:2]} * p8;
      z1_r  <= tag.zero;
      t1_r  <= tag.temp;
      p2_r  <= p1_r;
      mp9_r <= p9 * {13'd0, sq_r[31:13]};
      m8b_r <= m8_r;
      z2_r  <= z1_r;
      t2_r  <= t1_r;
      out_r.temp_centi  <= $signed(t2_r);
      // drop the result to zero when the divisor was zero
      out_r.pressure_pa <= z2_r ? 32'd0 : p2_r + corr;
    end
  end

  assign out_vld  = v_r[3];
  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- dv/ptc_checker.sv -----
// Checker for the pressure/temperature compensation unit: watches the input,
// result and register-write channels, predicts each result and compares.
// Depends on ptc_pkg for the payload types and register indexes.
module ptc_checker import ptc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  seen_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [47:0] cal_t;
  logic [63:0] cal_pl, cal_pm;
  logic [15:0] cal_ph;
  out_item_t   want_q[$];

  function automatic logic [31:0] sar(logic [31:0] v, int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sext(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic out_item_t compensate(in_item_t it);
    logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, q, qq, p;
    out_item_t r;
    at = {12'd0, it.raw_temp};
    ap = {12'd0, it.raw_pressure};
    t1 = {16'd0, cal_t[15:0]};
    t2 = sext(cal_t[31:16]);
    t3 = sext(cal_t[47:32]);
    p1 = {16'd0, cal_pl[15:0]};
    p2 = sext(cal_pl[31:16]);
    p3 = sext(cal_pl[47:32]);
    p4 = sext(cal_pl[63:48]);
    p5 = sext(cal_pm[15:0]);
    p6 = sext(cal_pm[31:16]);
    p7 = sext(cal_pm[47:32]);
    p8 = sext(cal_pm[63:48]);
    p9 = sext(cal_ph);
    a = sar(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = sar(sar(d * d, 12) * t3, 14);
    fine = a + b;
    r.temp_centi = sar(fine * 32'd5 + 32'd128, 8);
    a = sar(fine, 1) - 32'd64000;
    q = sar(a, 2);
    qq = q * q;
    b = sar(qq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sar(b, 2) + (p4 << 16);
    a = sar(sar(p3 * sar(qq, 13), 3) + sar(p2 * a, 1), 18);
    a = sar((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      p = 0;
    end else begin
      p = ((32'd1048576 - ap) - sar(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sar((p >> 2) * p8, 13);
      p = p + sar(a + b + p7, 4);
    end
    r.pressure_pa = p;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t w;
    if (!rst_n) begin
      cal_t <= '0;
      cal_pl <= '0;
      cal_pm <= '0;
      cal_ph <= '0;
      want_q.delete();
      fail_count = 0;
      seen_count <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) want_q.push_back(compensate(in_data));
      if (out_valid && out_ready) begin
        seen_count <= seen_count + 1;
        if (want_q.size() == 0) begin
          report("unexpected item", out_data.pressure_pa, '0);
        end else begin
          w = want_q.pop_front();
          if (out_data.temp_centi !== w.temp_centi)
            report("temp_centi", out_data.temp_centi, w.temp_centi);
          if (out_data.pressure_pa !== w.pressure_pa)
            report("pressure_pa", out_data.pressure_pa, w.pressure_pa);
        end
      end
      pending <= want_q.size();
      // registers change after this edge's prediction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegTempCal:  cal_t <= cfg_data[47:0];
          RegPressLow: cal_pl <= cfg_data;
          RegPressMid: cal_pm <= cfg_data;
          RegPressHi:  cal_ph <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- dv/tb_top.sv -----
// Top of the testbench: clock, reset, stimulus and verdict for the
// compensation unit. Depends on ptc_pkg and ptc_checker.
module tb_top;
  import ptc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 46;
  localparam int CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'd7;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int fail_count, pending, seen_count, cycle;
  bit calm;

  pressure_temp_compensation_unit uut (.*);

  ptc_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("timeout after %0d cycles", cycle);
      $display("** pressure_temp_compensation_unit: FAILED **");
      $finish;
    end
  end

  // result-side stalls in bursts
  int stall_left;
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(9) == 0) begin
      stall_left <= $urandom_range(4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [19:0] t, logic [19:0] p);
    int gap;
    if (!calm && $urandom_range(7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{raw_temp: t, raw_pressure: p};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // let the count see the last accepted item first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // typical datasheet-like calibration with random noise on each word
  function automatic logic [63:0] near(logic [63:0] base, logic [63:0] noise);
    return base ^ (noise & {4{16'h003f}});
  endfunction

  logic [63:0] rnd;
  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    cycle = 0;
    calm = 0;
    stall_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero calibration: divisor zero path
    send(20'd0, 20'd0);
    send(20'hfffff, 20'hfffff);
    drain();

    // nominal calibration, then field extremes
    write_reg(RegTempCal, {16'd0, 48'hfc18_6684_6e8e});
    write_reg(RegPressLow, 64'h0ac6_2c0c_d67e_8fa3);
    write_reg(RegPressMid, 64'hc108_0003_fff9_0072);
    write_reg(RegPressHi, 64'hffff_0000_0000_1770);
    write_reg(RegUnused, 64'hffff_ffff_ffff_ffff);
    send(20'd0, 20'd0);
    send(20'hfffff, 20'd0);
    send(20'd0, 20'hfffff);
    send(20'hfffff, 20'hfffff);
    send(20'h7e9c0, 20'h65b40);
    send(20'h80000, 20'h80000);
    send(20'h55555, 20'haaaaa);
    send(20'haaaaa, 20'h55555);
    drain();

    // all-ones extremes, then wrap-heavy settings
    write_reg(RegTempCal, '1);
    write_reg(RegPressLow, '1);
    write_reg(RegPressMid, '1);
    write_reg(RegPressHi, '1);
    send(20'd0, 20'd0);
    send(20'hfffff, 20'hfffff);
    send(20'h12345, 20'hedcba);
    drain();
    write_reg(RegTempCal, {16'd0, 48'h8000_7fff_ffff});
    write_reg(RegPressLow, 64'h8000_7fff_8000_0001);
    write_reg(RegPressMid, 64'h7fff_8000_7fff_8000);
    write_reg(RegPressHi, {48'd0, 16'h8000});
    send(20'd0, 20'hfffff);
    send(20'hfffff, 20'd0);
    drain();

    // random phases: mostly near-nominal calibration, some fully random
    for (int ph = 0; ph < 8; ph++) begin
      rnd = {$urandom, $urandom};
      if (ph % 3 == 2) begin
        write_reg(RegTempCal, rnd);
        write_reg(RegPressLow, {$urandom, $urandom});
        write_reg(RegPressMid, {$urandom, $urandom});
        write_reg(RegPressHi, {$urandom, $urandom});
      end else begin
        write_reg(RegTempCal, near({16'd0, 48'hfc18_6684_6e8e}, rnd));
        write_reg(RegPressLow, near(64'h0ac6_2c0c_d67e_8fa3, {$urandom, $urandom}));
        write_reg(RegPressMid, near(64'hc108_0003_fff9_0072, {$urandom, $urandom}));
        write_reg(RegPressHi, near({48'd0, 16'h1770}, {$urandom, $urandom}));
      end
      calm = (ph == 7);
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(3) != 0)
          send(20'($urandom_range(20'h90000, 20'h60000)),
               20'($urandom_range(20'h90000, 20'h30000)));
        else
          send(20'($urandom), 20'($urandom));
      end
      drain();
    end

    $display("Covered %0d results over zero, nominal, extreme and random calibrations,",
             seen_count);
    $display("with random input gaps and result stalls.");
    if (fail_count == 0) $display("** pressure_temp_compensation_unit: PASSED **");
    else $display("** pressure_temp_compensation_unit: FAILED **");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/ptc_pkg.sv
src/ptc_front.sv
src/ptc_div.sv
src/ptc_back.sv
src/pressure_temp_compensation_unit.sv
dv/ptc_checker.sv
dv/tb_top.sv
